// ===== rtl/fra_pkg.sv =====
// ---------------------------------------------------------------------------
// fra_pkg: shared types and constants of the frame reservation admission block
// Holds field widths, table sizes, status and action codes, and the structs
// that travel between the front, the engine and the result stage.
// ---------------------------------------------------------------------------
package fra_pkg;

  localparam int ID_W       = 16;
  localparam int NEED_W     = 16;
  localparam int MAX_JOBS   = 16;
  localparam int MAX_STEPS  = 16;
  localparam int SLOT_W     = $clog2(MAX_JOBS);
  localparam int STEP_W     = $clog2(MAX_STEPS);
  localparam int ADDR_W     = SLOT_W + STEP_W;
  localparam int DEPTH      = MAX_JOBS * MAX_STEPS;
  localparam int CNT_W      = SLOT_W + 1;
  localparam int LC_W       = STEP_W + 1;
  localparam int ACC_W      = NEED_W + SLOT_W;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;
  localparam logic [NEED_W-1:0] TOTAL_RESET = 16'd64;

  // Input actions; the reserved code takes no action of its own but still gets a response beat.
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_CMPL  = 2'd1;
  localparam logic [1:0] ACT_AWAIT = 2'd2;
  localparam logic [1:0] ACT_RSVD  = 2'd3;

  // Response status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EXCEEDS = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_INACT   = 3'd5;
  localparam logic [2:0] ST_ZERO    = 3'd6;

  // One classified input beat.
  typedef struct packed {
    logic              is_load;
    logic              is_cmpl;
    logic              is_await;
    logic [ID_W-1:0]   id;
    logic [NEED_W-1:0] need;
    logic              last;
  } item_t;

  // Response fields of one item.
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [2:0]      status;
    logic            flag;
  } rsp_t;

  // Activation notice written into the result buffer.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] idx;
    logic [ID_W-1:0]   id;
  } notice_t;

  // Hand-off of a finished item to the result stage.
  typedef struct packed {
    logic              commit;
    rsp_t              rsp;
    logic [NEED_W-1:0] free_frames;
    logic [CNT_W-1:0]  ncnt;
  } batch_t;

endpackage

// ===== rtl/fra_front.sv =====
// ---------------------------------------------------------------------------
// fra_front: input queue of the admission block
// Accepts input beats, decodes the action and holds up to two items for the
// engine so that the input side and the engine stall independently.
// ---------------------------------------------------------------------------
module fra_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [fra_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [1:0]                   s_axis_tuser,
  input  logic                         s_axis_tlast,
  output logic                         item_valid_o,
  input  logic                         item_pop_i,
  output fra_pkg::item_t               item_o
);

  fra_pkg::item_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  fra_pkg::item_t in_item;
  logic           push;

  // Decode the incoming beat.
  always_comb begin
    in_item.is_load  = (s_axis_tuser == fra_pkg::ACT_LOAD);
    in_item.is_cmpl  = (s_axis_tuser == fra_pkg::ACT_CMPL);
    in_item.is_await = (s_axis_tuser == fra_pkg::ACT_AWAIT);
    in_item.id       = s_axis_tdata[15:0];
    in_item.need     = s_axis_tdata[31:16];
    in_item.last     = s_axis_tlast;
  end

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid_o  = (cnt_q != 2'd0);
  assign item_o        = mem_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (item_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, item_pop_i};
    end
  end

endmodule

// ===== rtl/fra_engine.sv =====
// ---------------------------------------------------------------------------
// fra_engine: job table, plan memory and admission sequencer
// Carries out one item at a time: table update, suffix maximum over the
// loaded plan, a sweep that sums the reserved frames, and the admission pass.
// ---------------------------------------------------------------------------
module fra_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [fra_pkg::NEED_W-1:0]    total_i,
  input  logic                          item_valid_i,
  output logic                          item_pop_o,
  input  fra_pkg::item_t                item_i,
  input  logic                          out_busy_i,
  output fra_pkg::notice_t              notice_o,
  output fra_pkg::batch_t               batch_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SWR   = 4'd3;
  localparam logic [3:0] S_LCHK  = 4'd4;
  localparam logic [3:0] S_FREE  = 4'd5;
  localparam logic [3:0] S_FDONE = 4'd6;
  localparam logic [3:0] S_ACHK  = 4'd7;
  localparam logic [3:0] S_AUSE  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam int SW = fra_pkg::SLOT_W;
  localparam int TW = fra_pkg::STEP_W;
  localparam int NW = fra_pkg::NEED_W;
  localparam int CW = fra_pkg::CNT_W;
  localparam int LW = fra_pkg::LC_W;

  // Control state.
  logic [3:0]                  state_q, state_d;
  logic [fra_pkg::MAX_JOBS-1:0] valid_q, valid_d;
  logic [fra_pkg::MAX_JOBS-1:0] active_q, active_d;
  logic [fra_pkg::MAX_JOBS-1:0] waiting_q, waiting_d;
  logic [SW-1:0]               ld_slot_q, ld_slot_d;
  logic [LW-1:0]               lc_q, lc_d;
  logic [SW-1:0]               qhead_q, qhead_d;
  logic [CW-1:0]               qcnt_q, qcnt_d;
  logic [CW-1:0]               sw_q, sw_d;
  logic                        pend_q, pend_d;
  logic [CW-1:0]               ncnt_q, ncnt_d;

  // Working payload.
  fra_pkg::item_t              it_q;
  fra_pkg::rsp_t               rsp_q, rsp_d;
  logic [NW-1:0]               run_q, run_d;
  logic [NW-1:0]               lastneed_q, lastneed_d;
  logic [TW-1:0]               idx_q, idx_d;
  logic [TW-1:0]               nm1_q, nm1_d;
  logic [fra_pkg::ACC_W-1:0]   acc_q, acc_d;
  logic [NW-1:0]               freef_q, freef_d;
  logic [SW-1:0]               cs_q, cs_d;

  // Per-slot tables and queue.
  logic [fra_pkg::ID_W-1:0]    job_q [fra_pkg::MAX_JOBS];
  logic [TW-1:0]               step_q [fra_pkg::MAX_JOBS];
  logic [TW-1:0]               fin_q [fra_pkg::MAX_JOBS];
  logic [SW-1:0]               queue_q [fra_pkg::MAX_JOBS];
  logic [NW-1:0]               need_mem [fra_pkg::DEPTH];
  logic [NW-1:0]               rd_q;

  // Write and read strobes.
  logic                        job_we, step_we, fin_we, q_we, mem_we, rd_en;
  logic [SW-1:0]               job_widx, step_widx, fin_widx, q_widx;
  logic [TW-1:0]               step_wval, fin_wval;
  logic [SW-1:0]               q_wval;
  logic [fra_pkg::ADDR_W-1:0]  mem_waddr, rd_addr;
  logic [NW-1:0]               mem_wdata;

  // Lookup results.
  logic                        hit, free_any, ld_start;
  logic [SW-1:0]               hit_idx, free_idx, eff_slot, qs;
  logic [NW-1:0]               smax;

  // Job lookup and first free slot.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int s = 0; s < fra_pkg::MAX_JOBS; s++) begin
      if (valid_q[s] && (job_q[s] == it_q.id)) begin
        hit     = 1'b1;
        hit_idx = SW'(s);
      end
    end
    for (int s = fra_pkg::MAX_JOBS - 1; s >= 0; s--) begin
      if (!valid_q[s]) begin
        free_any = 1'b1;
        free_idx = SW'(s);
      end
    end
  end

  assign ld_start = (lc_q == '0);
  assign eff_slot = ld_start ? free_idx : ld_slot_q;
  assign qs       = queue_q[qhead_q];
  assign smax     = (run_q > rd_q) ? run_q : rd_q;

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    valid_d    = valid_q;
    active_d   = active_q;
    waiting_d  = waiting_q;
    ld_slot_d  = ld_slot_q;
    lc_d       = lc_q;
    qhead_d    = qhead_q;
    qcnt_d     = qcnt_q;
    sw_d       = sw_q;
    pend_d     = pend_q;
    ncnt_d     = ncnt_q;
    rsp_d      = rsp_q;
    run_d      = run_q;
    lastneed_d = lastneed_q;
    idx_d      = idx_q;
    nm1_d      = nm1_q;
    acc_d      = acc_q;
    freef_d    = freef_q;
    cs_d       = cs_q;
    item_pop_o = 1'b0;
    job_we     = 1'b0;
    job_widx   = eff_slot;
    step_we    = 1'b0;
    step_widx  = hit_idx;
    step_wval  = '0;
    fin_we     = 1'b0;
    fin_widx   = ld_slot_q;
    fin_wval   = nm1_q;
    q_we       = 1'b0;
    q_widx     = qhead_q + qcnt_q[SW-1:0];
    q_wval     = ld_slot_q;
    mem_we     = 1'b0;
    mem_waddr  = {eff_slot, lc_q[TW-1:0]};
    mem_wdata  = it_q.need;
    rd_en      = 1'b0;
    rd_addr    = {ld_slot_q, idx_q};
    notice_o   = '0;
    batch_o    = '0;

    case (state_q)
      S_IDLE: begin
        if (item_valid_i && !out_busy_i) begin
          item_pop_o = 1'b1;
          ncnt_d     = '0;
          state_d    = S_EXEC;
        end
      end

      S_EXEC: begin
        rsp_d.id     = it_q.id;
        rsp_d.status = fra_pkg::ST_OK;
        rsp_d.flag   = 1'b0;
        sw_d         = '0;
        pend_d       = 1'b0;
        acc_d        = '0;
        state_d      = S_FREE;
        if (it_q.is_load) begin
          if (ld_start && hit) begin
            rsp_d.status = fra_pkg::ST_DUP;
          end else if (ld_start && !free_any) begin
            rsp_d.status = fra_pkg::ST_FULL;
          end else begin
            if (ld_start) begin
              ld_slot_d = free_idx;
              job_we    = 1'b1;
            end else begin
              rsp_d.id = job_q[ld_slot_q];
            end
            if (lc_q >= LW'(fra_pkg::MAX_STEPS)) begin
              lc_d         = '0;
              rsp_d.status = fra_pkg::ST_FULL;
            end else begin
              mem_we = 1'b1;
              lc_d   = lc_q + 1'b1;
              if (it_q.last) begin
                lc_d       = '0;
                run_d      = it_q.need;
                lastneed_d = it_q.need;
                nm1_d      = lc_q[TW-1:0];
                if (ld_start) begin
                  state_d = S_LCHK;
                end else begin
                  idx_d   = lc_q[TW-1:0] - 1'b1;
                  state_d = S_SRD;
                end
              end
            end
          end
        end else if (it_q.is_cmpl) begin
          if (!hit) begin
            rsp_d.status = fra_pkg::ST_UNKNOWN;
          end else if (!active_q[hit_idx]) begin
            rsp_d.status = fra_pkg::ST_INACT;
          end else if (step_q[hit_idx] >= fin_q[hit_idx]) begin
            valid_d[hit_idx]   = 1'b0;
            active_d[hit_idx]  = 1'b0;
            waiting_d[hit_idx] = 1'b0;
          end else begin
            step_we    = 1'b1;
            step_wval  = step_q[hit_idx] + 1'b1;
            rsp_d.flag = 1'b1;
          end
        end else if (it_q.is_await) begin
          if (!hit) begin
            rsp_d.status = fra_pkg::ST_UNKNOWN;
          end else if (active_q[hit_idx]) begin
            rsp_d.flag = 1'b1;
          end else begin
            waiting_d[hit_idx] = 1'b1;
          end
        end
      end

      // Suffix maximum, walking the plan from the end toward step zero.
      S_SRD: begin
        rd_en   = 1'b1;
        state_d = S_SWR;
      end

      S_SWR: begin
        mem_we    = 1'b1;
        mem_waddr = {ld_slot_q, idx_q};
        mem_wdata = smax;
        run_d     = smax;
        if (idx_q == '0) begin
          state_d = S_LCHK;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = S_SRD;
        end
      end

      S_LCHK: begin
        state_d = S_FREE;
        if (run_q > total_i) begin
          rsp_d.status = fra_pkg::ST_EXCEEDS;
        end else if (lastneed_q == '0) begin
          rsp_d.status = fra_pkg::ST_ZERO;
        end else begin
          valid_d[ld_slot_q]   = 1'b1;
          active_d[ld_slot_q]  = 1'b0;
          waiting_d[ld_slot_q] = 1'b0;
          step_we              = 1'b1;
          step_widx            = ld_slot_q;
          step_wval            = '0;
          fin_we               = 1'b1;
          if (qcnt_q < CW'(fra_pkg::MAX_JOBS)) begin
            q_we   = 1'b1;
            qcnt_d = qcnt_q + 1'b1;
          end
        end
      end

      // Sum the current needs of the active jobs, one slot a cycle.
      S_FREE: begin
        acc_d  = acc_q + (pend_q ? fra_pkg::ACC_W'(rd_q) : '0);
        pend_d = 1'b0;
        sw_d   = sw_q + 1'b1;
        if (sw_q == CW'(fra_pkg::MAX_JOBS)) begin
          state_d = S_FDONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = {sw_q[SW-1:0], step_q[sw_q[SW-1:0]]};
          pend_d  = valid_q[sw_q[SW-1:0]] && active_q[sw_q[SW-1:0]];
        end
      end

      S_FDONE: begin
        freef_d = (acc_q >= fra_pkg::ACC_W'(total_i)) ? '0 : (total_i - acc_q[NW-1:0]);
        state_d = S_ACHK;
      end

      // Admission pass over the head of the queue.
      S_ACHK: begin
        if ((freef_q == '0) || (qcnt_q == '0)) begin
          state_d = S_DONE;
        end else if (!valid_q[qs]) begin
          qhead_d = qhead_q + 1'b1;
          qcnt_d  = qcnt_q - 1'b1;
        end else begin
          cs_d    = qs;
          rd_en   = 1'b1;
          rd_addr = {qs, step_q[qs]};
          state_d = S_AUSE;
        end
      end

      S_AUSE: begin
        if (!(rd_q < freef_q)) begin
          state_d = S_DONE;
        end else begin
          freef_d        = freef_q - rd_q;
          active_d[cs_q] = 1'b1;
          qhead_d        = qhead_q + 1'b1;
          qcnt_d         = qcnt_q - 1'b1;
          if (waiting_q[cs_q]) begin
            waiting_d[cs_q] = 1'b0;
            notice_o.we     = 1'b1;
            notice_o.idx    = ncnt_q[SW-1:0];
            notice_o.id     = job_q[cs_q];
            ncnt_d          = ncnt_q + 1'b1;
          end
          state_d = S_ACHK;
        end
      end

      S_DONE: begin
        batch_o.commit      = 1'b1;
        batch_o.rsp         = rsp_q;
        batch_o.free_frames = freef_q;
        batch_o.ncnt        = ncnt_q;
        state_d             = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      active_q  <= '0;
      waiting_q <= '0;
      ld_slot_q <= '0;
      lc_q      <= '0;
      qhead_q   <= '0;
      qcnt_q    <= '0;
      sw_q      <= '0;
      pend_q    <= 1'b0;
      ncnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      active_q  <= active_d;
      waiting_q <= waiting_d;
      ld_slot_q <= ld_slot_d;
      lc_q      <= lc_d;
      qhead_q   <= qhead_d;
      qcnt_q    <= qcnt_d;
      sw_q      <= sw_d;
      pend_q    <= pend_d;
      ncnt_q    <= ncnt_d;
    end
  end

  // Working payload and slot tables.
  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      it_q <= item_i;
    end
    rsp_q      <= rsp_d;
    run_q      <= run_d;
    lastneed_q <= lastneed_d;
    idx_q      <= idx_d;
    nm1_q      <= nm1_d;
    acc_q      <= acc_d;
    freef_q    <= freef_d;
    cs_q       <= cs_d;
    if (job_we) begin
      job_q[job_widx] <= it_q.id;
    end
    if (step_we) begin
      step_q[step_widx] <= step_wval;
    end
    if (fin_we) begin
      fin_q[fin_widx] <= fin_wval;
    end
    if (q_we) begin
      queue_q[q_widx] <= q_wval;
    end
  end

  // Plan memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      need_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= need_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/fra_out.sv =====
// ---------------------------------------------------------------------------
// fra_out: result stage of the admission block
// Holds the response and the activation notices of one item and sends them
// as output beats, the response first and the last beat marked.
// ---------------------------------------------------------------------------
module fra_out (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fra_pkg::notice_t                notice_i,
  input  fra_pkg::batch_t                 batch_i,
  output logic                            busy_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [fra_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);

  logic                           busy_q;
  logic [fra_pkg::CNT_W-1:0]      pos_q;
  fra_pkg::rsp_t                  rsp_q;
  logic [fra_pkg::NEED_W-1:0]     freef_q;
  logic [fra_pkg::CNT_W-1:0]      ncnt_q;
  logic [fra_pkg::ID_W-1:0]       buf_q [fra_pkg::MAX_JOBS];
  logic [fra_pkg::SLOT_W-1:0]     rd_idx;
  logic [fra_pkg::ID_W-1:0]       job;
  logic [2:0]                     status;
  logic                           flag;

  assign busy_o        = busy_q;
  assign m_axis_tvalid = busy_q;
  assign m_axis_tlast  = (pos_q == ncnt_q);
  assign m_axis_tuser  = (pos_q != '0);
  assign rd_idx        = pos_q[fra_pkg::SLOT_W-1:0] - 1'b1;

  // Select the response or a notice for the current beat.
  always_comb begin
    if (pos_q == '0) begin
      job    = rsp_q.id;
      status = rsp_q.status;
      flag   = rsp_q.flag;
    end else begin
      job    = buf_q[rd_idx];
      status = fra_pkg::ST_OK;
      flag   = 1'b0;
    end
  end

  assign m_axis_tdata = {4'd0, freef_q, flag, status, job};

  // Notice buffer and latched response.
  always_ff @(posedge clk_i) begin
    if (notice_i.we) begin
      buf_q[notice_i.idx] <= notice_i.id;
    end
    if (batch_i.commit) begin
      rsp_q   <= batch_i.rsp;
      freef_q <= batch_i.free_frames;
      ncnt_q  <= batch_i.ncnt;
    end
  end

  // Beat sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
    end else if (batch_i.commit) begin
      busy_q <= 1'b1;
      pos_q  <= '0;
    end else if (busy_q && m_axis_tready) begin
      if (m_axis_tlast) begin
        busy_q <= 1'b0;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/frame_reservation_admission_top.sv =====
// ---------------------------------------------------------------------------
// frame_reservation_admission_top: job admission against a frame pool
// Input beats load job plans, report completed steps or ask for activation
// notices. Every item returns one response beat (tuser 0), followed by one
// notice beat (tuser 1) for each waiting job that its admission pass
// activated; tlast marks the final beat of the item. All beats of one item
// carry the free frame count after that pass.
// The cfg channel writes total_frames (reset 64); it is always ready and must be
// written only while the block is idle; the block itself does not enforce this.
// The engine does one item at a time: the reserved-frame sweep reads the plan
// memory once per slot, a final plan step adds the pool check and, for a plan
// of more than one step, the suffix maximum, and the admission pass steps
// through each admitted job and each retired queue head in turn.
// A two-beat input queue takes new beats while the engine works. The engine
// starts the next item only once all beats of the previous one were taken,
// so a stalled receiver holds back the engine and then the input side.
// Reset empties the job table, queue and any partial plan load.
// ---------------------------------------------------------------------------
module frame_reservation_admission_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // box_id [15:0], step_frames [31:16]
  input  logic [1:0]  s_axis_tuser,  // action [1:0]
  input  logic        s_axis_tlast,  // last_step
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // job_id [15:0], status [18:16], flag [19],
                                     // free_frames [35:20], zero [39:36]
  output logic        m_axis_tuser,  // kind
  output logic        m_axis_tlast,  // last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i     // total_frames
);

  logic [fra_pkg::NEED_W-1:0] total_q;
  logic                       item_valid, item_pop, out_busy;
  fra_pkg::item_t             item;
  fra_pkg::notice_t           notice;
  fra_pkg::batch_t            batch;

  // Pool size register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= fra_pkg::TOTAL_RESET;
    end else if (cfg_valid_i) begin
      total_q <= cfg_data_i;
    end
  end

  fra_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop),
    .item_o       (item)
  );

  fra_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .total_i     (total_q),
    .item_valid_i(item_valid),
    .item_pop_o  (item_pop),
    .item_i      (item),
    .out_busy_i  (out_busy),
    .notice_o    (notice),
    .batch_o     (batch)
  );

  fra_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .notice_i     (notice),
    .batch_i      (batch),
    .busy_o       (out_busy),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

`ifndef SYNTHESIS
  // Notices never carry a status or a flag.
  a_notice_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[19:16] == 4'd0))
    else $error("notice beat with nonzero status or flag");

  // The free count never exceeds the pool.
  a_free_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[35:20] <= total_q))
    else $error("free frames above pool size");

  // The engine commits a new item only while the result stage is not busy.
  a_no_commit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    batch.commit |-> !out_busy)
    else $error("result committed while previous item still draining");

  // Status code seven is never produced.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[18:16] != 3'd7))
    else $error("undefined status code");
`endif

endmodule

// ===== sim/frame_reservation_admission_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_reservation_admission_checker: result predictor and comparator
// Watches the input, result and pool-size channels of the admission block.
// Every accepted input beat runs through a cycle-free model of the job table,
// plan memory and admission queue. The model's result beats are queued and
// each accepted output beat is compared field by field with the oldest one.
// ---------------------------------------------------------------------------
module frame_reservation_admission_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          beats_due_o
);

  // One predicted result beat.
  typedef struct packed {
    logic        kind;
    logic [15:0] job;
    logic [2:0]  status;
    logic        flag;
    logic [15:0] free;
    logic        last;
  } result_beat_t;

  result_beat_t beats_due[$];

  // Mirror of the block's state.
  logic [15:0] pool_frames;
  logic        job_valid   [fra_pkg::MAX_JOBS];
  logic [15:0] job_id_of   [fra_pkg::MAX_JOBS];
  logic        job_active  [fra_pkg::MAX_JOBS];
  logic        job_waiting [fra_pkg::MAX_JOBS];
  int unsigned job_step    [fra_pkg::MAX_JOBS];
  int unsigned job_final   [fra_pkg::MAX_JOBS];
  logic [15:0] plan_need   [fra_pkg::DEPTH];
  int unsigned admit_fifo  [fra_pkg::MAX_JOBS];
  int unsigned fifo_head;
  int unsigned fifo_count;
  int unsigned loading_slot;
  int unsigned loaded_steps;

  function automatic int find_job(logic [15:0] id);
    for (int s = 0; s < fra_pkg::MAX_JOBS; s++) begin
      if (job_valid[s] && job_id_of[s] == id) return s;
    end
    return -1;
  endfunction

  function automatic int unsigned step_need(int unsigned s);
    return plan_need[s * fra_pkg::MAX_STEPS + (job_step[s] % fra_pkg::MAX_STEPS)];
  endfunction

  // Pool minus the current needs of active jobs, floored at zero.
  function automatic int unsigned free_frames();
    int unsigned reserved;
    reserved = 0;
    for (int s = 0; s < fra_pkg::MAX_JOBS; s++) begin
      if (job_valid[s] && job_active[s]) reserved += step_need(s);
    end
    return (reserved >= pool_frames) ? 0 : pool_frames - reserved;
  endfunction

  // Plan step load; returns the status and the job id to report.
  task automatic load_step(input logic [15:0] id, input logic [15:0] need,
                           input logic lst, output logic [2:0] status,
                           output logic [15:0] job);
    int s;
    int unsigned base;
    int unsigned n;
    logic go;
    status = fra_pkg::ST_OK;
    job = id;
    go = 1'b1;
    if (loaded_steps == 0) begin
      if (find_job(id) >= 0) begin
        status = fra_pkg::ST_DUP;
        go = 1'b0;
      end else begin
        s = -1;
        for (int k = fra_pkg::MAX_JOBS - 1; k >= 0; k--) begin
          if (!job_valid[k]) s = k;
        end
        if (s < 0) begin
          status = fra_pkg::ST_FULL;
          go = 1'b0;
        end else begin
          loading_slot = s;
          job_id_of[s] = id;
        end
      end
    end
    if (go) begin
      job = job_id_of[loading_slot];
      if (loaded_steps >= fra_pkg::MAX_STEPS) begin
        loaded_steps = 0;
        status = fra_pkg::ST_FULL;
      end else begin
        base = loading_slot * fra_pkg::MAX_STEPS;
        plan_need[base + loaded_steps] = need;
        loaded_steps++;
        if (lst) begin
          n = loaded_steps;
          loaded_steps = 0;
          // Remaining need of a step is the largest need from there on.
          for (int i = n - 1; i > 0; i--) begin
            if (plan_need[base + i] > plan_need[base + i - 1])
              plan_need[base + i - 1] = plan_need[base + i];
          end
          if (plan_need[base] > pool_frames) begin
            status = fra_pkg::ST_EXCEEDS;
          end else if (plan_need[base + n - 1] == 0) begin
            status = fra_pkg::ST_ZERO;
          end else begin
            job_valid[loading_slot]   = 1'b1;
            job_active[loading_slot]  = 1'b0;
            job_waiting[loading_slot] = 1'b0;
            job_step[loading_slot]    = 0;
            job_final[loading_slot]   = n - 1;
            if (fifo_count < fra_pkg::MAX_JOBS) begin
              admit_fifo[(fifo_head + fifo_count) % fra_pkg::MAX_JOBS] = loading_slot;
              fifo_count++;
            end
          end
        end
      end
    end
  endtask

  // Full effect of one input beat: response, admission pass, notices.
  task automatic predict_item(input logic [1:0] act, input logic [15:0] id,
                              input logic [15:0] need, input logic lst);
    result_beat_t out[$];
    result_beat_t rb;
    logic [2:0]   status;
    logic [15:0]  job;
    logic         flag;
    int           s;
    int unsigned  avail;
    int unsigned  hs;
    int unsigned  nd;
    status = fra_pkg::ST_OK;
    job = id;
    flag = 1'b0;
    case (act)
      fra_pkg::ACT_LOAD: begin
        load_step(id, need, lst, status, job);
      end
      fra_pkg::ACT_CMPL: begin
        s = find_job(id);
        if (s < 0) begin
          status = fra_pkg::ST_UNKNOWN;
        end else if (!job_active[s]) begin
          status = fra_pkg::ST_INACT;
        end else if (job_step[s] >= job_final[s]) begin
          job_valid[s]   = 1'b0;
          job_active[s]  = 1'b0;
          job_waiting[s] = 1'b0;
        end else begin
          job_step[s]++;
          flag = 1'b1;
        end
      end
      fra_pkg::ACT_AWAIT: begin
        s = find_job(id);
        if (s < 0) status = fra_pkg::ST_UNKNOWN;
        else if (job_active[s]) flag = 1'b1;
        else job_waiting[s] = 1'b1;
      end
      default: ;
    endcase
    rb = '{kind: 1'b0, job: job, status: status, flag: flag, free: '0, last: 1'b0};
    out.push_back(rb);

    // Admission pass in queue order; retired heads are dropped.
    avail = free_frames();
    while (avail != 0 && fifo_count != 0) begin
      hs = admit_fifo[fifo_head % fra_pkg::MAX_JOBS] % fra_pkg::MAX_JOBS;
      if (!job_valid[hs]) begin
        fifo_head = (fifo_head + 1) % fra_pkg::MAX_JOBS;
        fifo_count--;
        continue;
      end
      nd = step_need(hs);
      if (!(nd < avail)) break;
      avail -= nd;
      job_active[hs] = 1'b1;
      fifo_head = (fifo_head + 1) % fra_pkg::MAX_JOBS;
      fifo_count--;
      if (job_waiting[hs]) begin
        job_waiting[hs] = 1'b0;
        rb = '{kind: 1'b1, job: job_id_of[hs], status: fra_pkg::ST_OK, flag: 1'b0,
               free: '0, last: 1'b0};
        out.push_back(rb);
      end
    end
    foreach (out[k]) begin
      rb = out[k];
      rb.free = avail[15:0];
      rb.last = (k == out.size() - 1);
      beats_due.push_back(rb);
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_count_o++;
    end
  endtask

  // Prediction on input beats and pool writes, comparison on result beats.
  always @(posedge clk_i or negedge rst_ni) begin
    result_beat_t e;
    if (!rst_ni) begin
      pool_frames  = fra_pkg::TOTAL_RESET;
      fail_count_o = 0;
      beats_due_o  <= 0;
      fifo_head    = 0;
      fifo_count   = 0;
      loading_slot = 0;
      loaded_steps = 0;
      beats_due.delete();
      for (int s = 0; s < fra_pkg::MAX_JOBS; s++) begin
        job_valid[s]   = 1'b0;
        job_active[s]  = 1'b0;
        job_waiting[s] = 1'b0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) pool_frames = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        predict_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                     s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (beats_due.size() == 0) begin
          $error("result beat with no result expected: job %0h",
                 m_axis_tdata[15:0]);
          fail_count_o++;
        end else begin
          e = beats_due.pop_front();
          check_field("kind", e.kind, m_axis_tuser);
          check_field("job_id", e.job, m_axis_tdata[15:0]);
          check_field("status", e.status, m_axis_tdata[18:16]);
          check_field("flag", e.flag, m_axis_tdata[19]);
          check_field("free_frames", e.free, m_axis_tdata[35:20]);
          check_field("zero_pad", 0, m_axis_tdata[39:36]);
          check_field("last", e.last, m_axis_tlast);
        end
      end
      beats_due_o <= beats_due.size();
    end
  end

endmodule

// ===== sim/frame_reservation_admission_top_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_reservation_admission_top_tb: admission block testbench
// Drives directed and random plan loads, step completions and activation
// requests through several pool sizes, with random gaps and stalls on both
// streams, one long output hold and idle pauses for pool writes. The checker
// beside the block predicts and compares every result beat.
// ---------------------------------------------------------------------------
module frame_reservation_admission_top_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int PHASE_ITEMS    = 64;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  int          fail_count;
  int          beats_due;
  int          quiet_cycles = 0;
  logic        gaps_on = 1'b1;
  logic        long_hold = 1'b0;
  logic [15:0] pool_now = fra_pkg::TOTAL_RESET;

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  frame_reservation_admission_top i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  frame_reservation_admission_checker i_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fail_count_o(fail_count), .beats_due_o(beats_due)
  );

  // Watchdog on cycles with no beat on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("frame_reservation_admission_top_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall bursts, one long hold on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (gaps_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat (gaps_on ? $urandom_range(1, 20) : 1) @(posedge clk_i);
    end
  end

  // One input beat, with an occasional gap burst ahead of it.
  task automatic send_item(input logic [1:0] act, input logic [15:0] id,
                           input logic [15:0] need, input logic lst);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {need, id};
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Pool write while the block is idle.
  task automatic set_pool(input logic [15:0] frames);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (beats_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= frames;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pool_now = frames;
  endtask

  function automatic logic [15:0] pick_id();
    return ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
  endfunction

  function automatic logic [15:0] pick_need();
    int unsigned cap;
    cap = (pool_now < 6) ? pool_now : pool_now / 3;
    return ($urandom_range(0, 11) == 0) ? 16'($urandom) : 16'($urandom_range(0, cap));
  endfunction

  // Random mix: mostly well-formed plans, completions and awaits.
  task automatic random_phase(input int count);
    int sent;
    int steps;
    logic [15:0] id;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          id = pick_id();
          steps = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16)
                                              : $urandom_range(1, 4);
          for (int k = 0; k < steps; k++) begin
            send_item(fra_pkg::ACT_LOAD, (k == 0) ? id : 16'($urandom), pick_need(),
                      k == steps - 1);
            sent++;
            // A completion or await may slip in between plan steps.
            if (k < steps - 1 && $urandom_range(0, 5) == 0) begin
              send_item($urandom_range(0, 1) ? fra_pkg::ACT_CMPL : fra_pkg::ACT_AWAIT,
                        ($urandom_range(0, 1) ? id : pick_id()), 16'($urandom), 1'b0);
              sent++;
            end
          end
        end
        3, 4, 5, 6: begin
          send_item(fra_pkg::ACT_CMPL, pick_id(), 16'($urandom), 1'($urandom));
          sent++;
        end
        7, 8: begin
          send_item(fra_pkg::ACT_AWAIT, pick_id(), 16'($urandom), 1'($urandom));
          sent++;
        end
        default: begin
          send_item(fra_pkg::ACT_RSVD, 16'($urandom), 16'($urandom), 1'($urandom));
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases at the reset pool of 64.
    send_item(fra_pkg::ACT_LOAD, 16'h0001, 16'hFFFF, 1'b1);  // exceeds the pool
    send_item(fra_pkg::ACT_LOAD, 16'h0002, 16'h0000, 1'b1);  // zero final need
    send_item(fra_pkg::ACT_LOAD, 16'h0003, 16'd5, 1'b0);
    send_item(fra_pkg::ACT_LOAD, 16'h0000, 16'd20, 1'b0);
    send_item(fra_pkg::ACT_LOAD, 16'h0000, 16'd3, 1'b1);     // admitted
    send_item(fra_pkg::ACT_LOAD, 16'h0003, 16'd1, 1'b1);     // duplicate
    send_item(fra_pkg::ACT_AWAIT, 16'h0003, 16'd0, 1'b0);    // already active
    send_item(fra_pkg::ACT_LOAD, 16'h0004, 16'd50, 1'b1);    // queued behind the pool
    send_item(fra_pkg::ACT_AWAIT, 16'h0004, 16'd0, 1'b0);
    send_item(fra_pkg::ACT_CMPL, 16'h0004, 16'd0, 1'b0);     // inactive
    send_item(fra_pkg::ACT_CMPL, 16'hFFFF, 16'd0, 1'b0);     // unknown
    send_item(fra_pkg::ACT_AWAIT, 16'hABCD, 16'd0, 1'b1);    // unknown
    repeat (3) send_item(fra_pkg::ACT_CMPL, 16'h0003, 16'd0, 1'b0);  // retire, notice
    send_item(fra_pkg::ACT_RSVD, 16'h5A5A, 16'hA5A5, 1'b1);  // reserved action, answered with a response beat
    for (int k = 0; k < 17; k++)                             // plan too long
      send_item(fra_pkg::ACT_LOAD, 16'h0007, 16'd1, 1'b0);
    send_item(fra_pkg::ACT_LOAD, 16'h0009, 16'd2, 1'b0);
    send_item(fra_pkg::ACT_AWAIT, 16'h0009, 16'd0, 1'b0);    // job under load is unknown
    send_item(fra_pkg::ACT_LOAD, 16'hFFFF, 16'd2, 1'b1);

    random_phase(PHASE_ITEMS);
    set_pool(16'd1);
    random_phase(PHASE_ITEMS / 2);
    set_pool(16'hFFFF);
    long_hold = 1'b1;
    random_phase(PHASE_ITEMS);
    set_pool(16'($urandom_range(2, 200)));
    random_phase(PHASE_ITEMS);
    set_pool(16'd64);
    gaps_on = 1'b0;
    random_phase(PHASE_ITEMS);

    // Drain and verdict.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (beats_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("frame_reservation_admission_top_tb: done, clean");
    end else begin
      $display("frame_reservation_admission_top_tb: done, errors");
    end
    $finish;
  end

endmodule
